// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// Package for the rational arithmetic unit: field widths, operation kinds,
// sequencer states and the control/status structs of the shared unit. No dependencies.
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;
  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_DATA_BITS = 2 * FIELD_BITS;

  typedef enum logic [1:0] {
    KIND_REDUCE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_EQ     = 2'd3
  } kind_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_D,
    S_GCD_LD,
    S_GCD_CHK,
    S_GCD_REM,
    S_ADD_L,
    S_ADD_FA,
    S_ADD_FB,
    S_ADD_M1,
    S_ADD_M2,
    S_RED_N,
    S_RED_D,
    S_DONE
  } state_t;

endpackage

// ===== rtl/rau_alu.sv =====
`timescale 1ns / 1ps
// Shared iterative arithmetic unit: shift-add multiplier and restoring
// truncating divider, one bit per cycle. Depends on rau_pkg.
module rau_alu import rau_pkg::*; #(
  parameter int WordBits = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alu_ctl_t            ctl,
  input  logic [WordBits-1:0] opa,
  input  logic [WordBits-1:0] opb,
  output alu_sts_t            sts,
  output logic [WordBits-1:0] quo,
  output logic [WordBits-1:0] rem
);

  localparam int CntBits = $clog2(WordBits);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(WordBits - 1);

  logic                busy_r;
  logic                done_r;
  logic                dz_r;
  alu_op_t             op_r;
  logic [CntBits-1:0]  cnt_r;
  logic [WordBits-1:0] acc_r;
  logic [WordBits-1:0] sh_r;
  logic [WordBits-1:0] dv_r;
  logic                qneg_r;
  logic                rneg_r;

  logic [WordBits-1:0] mag_a;
  logic [WordBits-1:0] mag_b;
  logic [WordBits:0]   trial;
  logic [WordBits-1:0] mul_sum;

  assign mag_a   = opa[WordBits-1] ? (~opa + 1'b1) : opa;
  assign mag_b   = opb[WordBits-1] ? (~opb + 1'b1) : opb;
  assign trial   = {acc_r, sh_r[WordBits-1]} - {1'b0, dv_r};
  assign mul_sum = acc_r + (sh_r[0] ? dv_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        op_r   <= ctl.op;
        cnt_r  <= LastCnt;
        acc_r  <= '0;
        qneg_r <= opa[WordBits-1] ^ opb[WordBits-1];
        rneg_r <= opa[WordBits-1];
        dz_r   <= 1'b0;
        if (ctl.op == ALU_MUL) begin
          busy_r <= 1'b1;
          sh_r   <= opb;
          dv_r   <= opa;
        end else if (opb == '0) begin
          // Division by zero finishes at once with zero quotient and remainder.
          busy_r <= 1'b0;
          done_r <= 1'b1;
          dz_r   <= 1'b1;
          sh_r   <= '0;
          dv_r   <= '0;
        end else begin
          busy_r <= 1'b1;
          sh_r   <= mag_a;
          dv_r   <= mag_b;
        end
      end else if (busy_r) begin
        if (op_r == ALU_MUL) begin
          acc_r <= mul_sum;
          dv_r  <= dv_r << 1;
          sh_r  <= sh_r >> 1;
        end else if (!trial[WordBits]) begin
          acc_r <= trial[WordBits-1:0];
          sh_r  <= {sh_r[WordBits-2:0], 1'b1};
        end else begin
          acc_r <= {acc_r[WordBits-2:0], sh_r[WordBits-1]};
          sh_r  <= {sh_r[WordBits-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (op_r == ALU_MUL) begin
      quo = acc_r;
      rem = '0;
    end else begin
      quo = qneg_r ? (~sh_r + 1'b1) : sh_r;
      rem = rneg_r ? (~acc_r + 1'b1) : acc_r;
    end
  end

  assign sts.done     = done_r;
  assign sts.div_zero = dz_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("shared unit started while busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("shared unit done while still busy");

  a_dz_is_div: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dz_r) |-> (op_r == ALU_DIV && sh_r == '0))
    else $error("divide-by-zero flag without zero quotient");

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: handshake, operand registers
// and the sequencer. Depends on rau_pkg and rau_alu.
//
// The block takes one item at a time: an operation kind in in_tuser and two
// rationals a and b in in_tdata. It reduces a, multiplies, adds through the lcm of
// the denominators, or tests the raw fields for exact equality. All arithmetic runs
// in two's complement at WORD_BITS bits and wraps; fields are sign-extended or
// truncated between the 32-bit ports and that width. Every multiply, divide and
// remainder runs on one shared shift-add / restoring-divide unit that retires one
// bit per cycle. The Euclid gcd takes one remainder per step, and an add takes two
// gcd runs, five divides and three multiplies. in_tready is high only while the
// sequencer is idle. The result sits in an output register, so the next item is
// taken while the last result still waits. A division by zero anywhere sets
// div_error and forces both result parts to zero.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [1:0]               in_tuser,   // kind
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // res_num, res_den
  output logic [1:0]               out_tuser   // is_equal, div_error
);

  state_t state_r, state_nxt;
  logic   go_r;
  kind_t  kind_r;
  logic   phase_r;
  logic   err_r;
  logic   eq_r;

  logic [WORD_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic [WORD_BITS-1:0] n_r, d_r, p_r, l_r, fa_r, fb_r, x_r, y_r;

  logic                    out_valid_r;
  logic [FIELD_BITS-1:0]   out_num_r, out_den_r;
  logic                    out_eq_r, out_err_r;

  alu_ctl_t             alu_ctl;
  alu_sts_t             alu_sts;
  logic [WORD_BITS-1:0] alu_a, alu_b, alu_quo, alu_rem;

  logic in_fire;
  logic out_free;
  logic first_gcd;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // The first gcd of an add works on the two denominators.
  assign first_gcd = (kind_r == KIND_ADD) && !phase_r;

  rau_alu #(.WordBits(WORD_BITS)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (alu_a),
    .opb   (alu_b),
    .sts   (alu_sts),
    .quo   (alu_quo),
    .rem   (alu_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (kind_t'(in_tuser))
            KIND_REDUCE: state_nxt = S_GCD_LD;
            KIND_MUL:    state_nxt = S_MUL_N;
            KIND_ADD:    state_nxt = S_MUL_D;
            KIND_EQ:     state_nxt = S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL_N:   if (alu_sts.done) state_nxt = S_MUL_D;
      S_MUL_D:   if (alu_sts.done) state_nxt = S_GCD_LD;
      S_GCD_LD:  state_nxt = S_GCD_CHK;
      S_GCD_CHK: begin
        if (y_r != '0) begin
          state_nxt = S_GCD_REM;
        end else if (first_gcd) begin
          state_nxt = S_ADD_L;
        end else begin
          state_nxt = S_RED_N;
        end
      end
      S_GCD_REM: if (alu_sts.done) state_nxt = S_GCD_CHK;
      S_ADD_L:   if (alu_sts.done) state_nxt = S_ADD_FA;
      S_ADD_FA:  if (alu_sts.done) state_nxt = S_ADD_FB;
      S_ADD_FB:  if (alu_sts.done) state_nxt = S_ADD_M1;
      S_ADD_M1:  if (alu_sts.done) state_nxt = S_ADD_M2;
      S_ADD_M2:  if (alu_sts.done) state_nxt = S_GCD_LD;
      S_RED_N:   if (alu_sts.done) state_nxt = S_RED_D;
      S_RED_D:   if (alu_sts.done) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Shared unit control: each compute state issues its operation once, in
  // the first cycle after it is entered, then waits for done.
  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.op    = ALU_DIV;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state_r)
      S_MUL_N:   begin alu_ctl.start = go_r; alu_ctl.op = ALU_MUL; alu_a = an_r; alu_b = bn_r; end
      S_MUL_D:   begin alu_ctl.start = go_r; alu_ctl.op = ALU_MUL; alu_a = ad_r; alu_b = bd_r; end
      S_GCD_REM: begin alu_ctl.start = go_r; alu_a = x_r; alu_b = y_r; end
      S_ADD_L:   begin alu_ctl.start = go_r; alu_a = p_r; alu_b = x_r; end
      S_ADD_FA:  begin alu_ctl.start = go_r; alu_a = l_r; alu_b = ad_r; end
      S_ADD_FB:  begin alu_ctl.start = go_r; alu_a = l_r; alu_b = bd_r; end
      S_ADD_M1:  begin alu_ctl.start = go_r; alu_ctl.op = ALU_MUL; alu_a = an_r; alu_b = fa_r; end
      S_ADD_M2:  begin alu_ctl.start = go_r; alu_ctl.op = ALU_MUL; alu_a = bn_r; alu_b = fb_r; end
      S_RED_N:   begin alu_ctl.start = go_r; alu_a = n_r; alu_b = x_r; end
      S_RED_D:   begin alu_ctl.start = go_r; alu_a = d_r; alu_b = x_r; end
      default:   begin alu_ctl.start = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= kind_t'(in_tuser);
      phase_r <= 1'b0;
      err_r   <= 1'b0;
      eq_r    <= (in_tdata[31:0] == in_tdata[95:64]) &&
                 (in_tdata[63:32] == in_tdata[127:96]);
      an_r    <= WORD_BITS'($signed(in_tdata[31:0]));
      ad_r    <= WORD_BITS'($signed(in_tdata[63:32]));
      bn_r    <= WORD_BITS'($signed(in_tdata[95:64]));
      bd_r    <= WORD_BITS'($signed(in_tdata[127:96]));
      n_r     <= WORD_BITS'($signed(in_tdata[31:0]));
      d_r     <= WORD_BITS'($signed(in_tdata[63:32]));
    end
    if (state_r == S_GCD_LD) begin
      x_r <= first_gcd ? ad_r : n_r;
      y_r <= first_gcd ? bd_r : d_r;
    end
    if (alu_sts.done) begin
      case (state_r)
        S_MUL_N:   n_r <= alu_quo;
        S_MUL_D:   begin
          if (kind_r == KIND_MUL) begin
            d_r <= alu_quo;
          end else begin
            p_r <= alu_quo;
          end
        end
        S_GCD_REM: begin x_r <= y_r; y_r <= alu_rem; end
        S_ADD_L:   l_r  <= alu_quo;
        S_ADD_FA:  fa_r <= alu_quo;
        S_ADD_FB:  fb_r <= alu_quo;
        S_ADD_M1:  n_r  <= alu_quo;
        S_ADD_M2:  begin n_r <= n_r + alu_quo; d_r <= l_r; phase_r <= 1'b1; end
        S_RED_N:   n_r  <= alu_quo;
        S_RED_D:   d_r  <= alu_quo;
        default:   ;
      endcase
      if (alu_sts.div_zero) begin
        err_r <= 1'b1;
      end
    end
  end

  // Output register: loaded from the finished item once the last result left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      if (kind_r == KIND_EQ || err_r) begin
        out_num_r <= '0;
        out_den_r <= '0;
      end else begin
        out_num_r <= FIELD_BITS'($signed(n_r));
        out_den_r <= FIELD_BITS'($signed(d_r));
      end
      out_eq_r  <= (kind_r == KIND_EQ) && eq_r;
      out_err_r <= (kind_r != KIND_EQ) && err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_den_r, out_num_r};
  assign out_tuser  = {out_err_r, out_eq_r};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0))
    else $error("error result with nonzero parts");

  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tuser[1] && out_tdata == '0))
    else $error("equality result with parts or error");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!alu_ctl.start && !alu_sts.done))
    else $error("shared unit active while sequencer idle");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the rational arithmetic unit: directed and random items checked
// against a built-in predictor of reduce, multiply, add and equality. Depends on rau_pkg and rational_arithmetic_unit.
module tb_top;
  import rau_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        eq;
    logic        err;
  } rat_result_t;

  rat_result_t pending_results[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Truncating divide with the most negative over minus one wrapping.
  function automatic logic [31:0] tdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Remainder takes the sign of the dividend.
  function automatic logic [31:0] trem(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r = ma % mb;
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] signed_gcd(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = b;
      b = trem(a, b);
      a = t;
    end
    return a;
  endfunction

  function automatic logic [31:0] checked_div(logic [31:0] a, logic [31:0] b,
                                              inout logic err);
    if (b == 0) begin
      err = 1'b1;
      return 32'd0;
    end
    return tdiv(a, b);
  endfunction

  function automatic rat_result_t rational_result(kind_t k, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    rat_result_t r;
    logic [31:0] n, d, g, l, fa, fb;
    logic err;
    err = 1'b0;
    r = '0;
    n = 0;
    d = 0;
    case (k)
      KIND_REDUCE: begin
        n = an;
        d = ad;
      end
      KIND_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      KIND_ADD: begin
        l = checked_div(ad * bd, signed_gcd(ad, bd), err);
        fa = checked_div(l, ad, err);
        fb = checked_div(l, bd, err);
        n = an * fa + bn * fb;
        d = l;
      end
      default: r.eq = (an == bn) && (ad == bd);
    endcase
    if (k != KIND_EQ) begin
      g = signed_gcd(n, d);
      r.num = checked_div(n, g, err);
      r.den = checked_div(d, g, err);
    end
    if (err) begin
      r.num = 0;
      r.den = 0;
    end
    r.err = err;
    return r;
  endfunction

  // in_tvalid stays high after an accepted item; the next call either offers a
  // new item at once or drops it while the sender idles.
  task automatic send_item(kind_t k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results = {pending_results, rational_result(k, an, ad, bn, bd)};
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rat_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.num || out_tdata[63:32] !== want.den ||
            out_tuser[0] !== want.eq || out_tuser[1] !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected num %h den %h eq %b err %b, got %h %h %b %b",
                     want.num, want.den, want.eq, want.err, out_tdata[31:0],
                     out_tdata[63:32], out_tuser[0], out_tuser[1]);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom;
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  task automatic test_directed();
    send_item(KIND_REDUCE, 6, 4, 0, 0);
    send_item(KIND_REDUCE, -6, 4, 0, 0);
    send_item(KIND_REDUCE, 6, -4, 0, 0);
    send_item(KIND_REDUCE, 5, 0, 0, 0);
    send_item(KIND_REDUCE, 0, 0, 0, 0);
    send_item(KIND_REDUCE, 32'h8000_0000, -1, 0, 0);
    send_item(KIND_REDUCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_item(KIND_MUL, 3, 4, 2, 9);
    send_item(KIND_MUL, 32'h7fff_ffff, 3, 32'h7fff_ffff, 5);
    send_item(KIND_MUL, 1, 0, 2, 3);
    send_item(KIND_ADD, 1, 2, 1, 3);
    send_item(KIND_ADD, -1, 6, 1, -4);
    send_item(KIND_ADD, 1, 0, 1, 3);
    send_item(KIND_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_item(KIND_ADD, 1, 32'h8000_0000, 1, -1);
    send_item(KIND_EQ, 2, 4, 2, 4);
    send_item(KIND_EQ, 1, 2, 2, 4);
    send_item(KIND_EQ, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(KIND_EQ, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [31:0] an, ad;
    for (int i = 0; i < count; i++) begin
      an = rand_word();
      ad = rand_word();
      if ($urandom_range(3) == 0)
        send_item(KIND_EQ, an, ad, $urandom_range(1) ? an : rand_word(), ad);
      else
        send_item(kind_t'($urandom_range(2)), an, ad, rand_word(), rand_word());
    end
  endtask

  // The receiver holds off while the sender keeps offering, filling the block.
  task automatic test_back_pressure();
    hold_off_cycles <= 9000;
    repeat (4) send_item(KIND_ADD, rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(70);
    send_idle_pct = 51;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(70);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_back_pressure();
    drain();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
